// ===== rtl/vcsl_pkg.sv =====
package vcsl_pkg;

    localparam int VEL_WIDTH = 32;
    localparam int VEL_FRAC_BITS = 24;

    localparam int DIFF_W = VEL_WIDTH + 1;
    localparam int SQ_W = 2 * DIFF_W + 2;
    localparam int ROOT_W = SQ_W / 2;
    localparam int ROOT_CNT_W = $clog2(ROOT_W + 1);
    localparam int PROD_W = DIFF_W + 24;
    localparam int DIV_CNT_W = $clog2(PROD_W + 1);
    localparam int SIL_W = 24;

    localparam logic [1:0] MODE_TICK = 2'd0;
    localparam logic [1:0] MODE_CMD = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;

    localparam logic [2:0] REG_DECAY = 3'd0;
    localparam logic [2:0] REG_TIMEOUT = 3'd1;
    localparam logic [2:0] REG_FORCE = 3'd2;
    localparam logic [2:0] REG_LIN_STEP = 3'd3;
    localparam logic [2:0] REG_ANG_STEP = 3'd4;

    typedef struct packed {
        logic load_cmd;
        logic clear_target;
        logic tick_front;
        logic diff_load;
        logic sqrt_start;
        logic div_start;
        logic commit;
        logic group;
        logic [1:0] axis;
        logic emit;
    } vcsl_cmd_t;

    typedef struct packed {
        logic sqrt_done;
        logic div_done;
        logic need_scale;
    } vcsl_status_t;

endpackage

// ===== rtl/vcsl_ctrl.sv =====
module vcsl_ctrl
    import vcsl_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [1:0]   mode,
    output logic         out_valid,
    input  logic         out_ready,
    output vcsl_cmd_t    cmd,
    input  vcsl_status_t status
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIFF = 3'd1;
    localparam logic [2:0] S_SQRT = 3'd2;
    localparam logic [2:0] S_DIV = 3'd3;
    localparam logic [2:0] S_COMMIT = 3'd4;
    localparam logic [2:0] S_OUT = 3'd5;
    localparam logic [2:0] S_DIVGO = 3'd6;

    logic [2:0] state_reg, state_next;
    logic group_reg, group_next;
    logic [1:0] axis_reg, axis_next;
    logic out_valid_reg, out_valid_next;

    assign in_ready = (state_reg == S_IDLE) && !out_valid_reg;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        group_next = group_reg;
        axis_next = axis_reg;
        out_valid_next = out_valid_reg;
        cmd = '0;
        cmd.group = group_reg;
        cmd.axis = axis_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    case (mode)
                        MODE_CMD: cmd.load_cmd = 1'b1;
                        MODE_CLEAR: cmd.clear_target = 1'b1;
                        MODE_TICK:
                        begin
                            cmd.tick_front = 1'b1;
                            group_next = 1'b0;
                            state_next = S_DIFF;
                        end
                        default: ;
                    endcase
                end
            end
            S_DIFF:
            begin
                cmd.diff_load = 1'b1;
                state_next = S_SQRT;
            end
            S_SQRT:
            begin
                cmd.sqrt_start = 1'b0;
                if (status.sqrt_done)
                begin
                    axis_next = 2'd0;
                    if (status.need_scale)
                    begin
                        state_next = S_DIVGO;
                    end
                    else
                    begin
                        state_next = S_COMMIT;
                    end
                end
            end
            // launch the divider for the current axis
            S_DIVGO:
            begin
                cmd.div_start = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (status.div_done)
                begin
                    if (axis_reg == 2'd2)
                    begin
                        state_next = S_COMMIT;
                    end
                    else
                    begin
                        axis_next = axis_reg + 2'd1;
                        state_next = S_DIVGO;
                    end
                end
            end
            S_COMMIT:
            begin
                cmd.commit = 1'b1;
                if (group_reg)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    group_next = 1'b1;
                    state_next = S_DIFF;
                end
            end
            S_OUT:
            begin
                cmd.emit = 1'b1;
                out_valid_next = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
        if (state_reg == S_DIFF)
        begin
            cmd.sqrt_start = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            group_reg <= 1'b0;
            axis_reg <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            group_reg <= group_next;
            axis_reg <= axis_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== rtl/vcsl_datapath.sv =====
module vcsl_datapath
    import vcsl_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    input  logic [2:0]          cfg_index,
    input  logic [23:0]         cfg_data,
    input  logic signed [31:0]  lin_x,
    input  logic signed [31:0]  lin_y,
    input  logic signed [31:0]  lin_z,
    input  logic signed [31:0]  ang_x,
    input  logic signed [31:0]  ang_y,
    input  logic signed [31:0]  ang_z,
    input  logic signed [23:0]  force_x,
    input  logic signed [23:0]  force_y,
    input  logic signed [23:0]  force_z,
    input  logic [19:0]         period_us,
    input  logic                command_ok,
    input  vcsl_cmd_t           cmd,
    output vcsl_status_t        status,
    output logic signed [31:0]  out_lin_x,
    output logic signed [31:0]  out_lin_y,
    output logic signed [31:0]  out_lin_z,
    output logic signed [31:0]  out_ang_x,
    output logic signed [31:0]  out_ang_y,
    output logic signed [31:0]  out_ang_z,
    output logic                force_clamped
);

    logic [15:0] decay_reg;
    logic [22:0] timeout_reg;
    logic [22:0] force_lim_reg;
    logic [23:0] lin_step_reg;
    logic [23:0] ang_step_reg;

    logic signed [VEL_WIDTH-1:0] target_reg [6];
    logic signed [VEL_WIDTH-1:0] shaped_reg [6];
    logic [SIL_W-1:0] silence_reg;
    logic fresh_reg;
    logic clamp_reg;
    logic [2:0] fsign_reg;
    logic signed [DIFF_W-1:0] diff_reg [3];
    logic signed [DIFF_W-1:0] delta_reg [3];
    logic [ROOT_W-1:0] norm_reg;

    logic signed [31:0] out_reg [6];
    logic out_clamp_reg;

    logic signed [31:0] cmd_in [6];
    assign cmd_in[0] = lin_x;
    assign cmd_in[1] = lin_y;
    assign cmd_in[2] = lin_z;
    assign cmd_in[3] = ang_x;
    assign cmd_in[4] = ang_y;
    assign cmd_in[5] = ang_z;

    // tick front end: timer, decay, clamp decision
    logic [SIL_W:0] sil_sum;
    logic [SIL_W-1:0] sil_new;
    logic decay_on;
    logic [47:0] fsq;
    logic [51:0] fsq16;
    logic [51:0] thr;
    logic clamp_new;
    logic signed [VEL_WIDTH-1:0] target_dec [6];
    logic [VEL_WIDTH+15:0] dec_prod [6];
    logic [VEL_WIDTH-1:0] tmag [6];

    always_comb
    begin
        sil_sum = {1'b0, silence_reg} + {{(SIL_W - 19){1'b0}}, period_us};
        if (fresh_reg)
        begin
            sil_new = '0;
        end
        else if (sil_sum[SIL_W])
        begin
            sil_new = '1;
        end
        else
        begin
            sil_new = sil_sum[SIL_W-1:0];
        end
        decay_on = {1'b0, sil_new} > {1'b0, timeout_reg, 1'b0};
        for (int i = 0; i < 6; i++)
        begin
            tmag[i] = target_reg[i][VEL_WIDTH-1] ? (~target_reg[i] + 1'b1) : target_reg[i];
            dec_prod[i] = tmag[i] * decay_reg;
            if (decay_on)
            begin
                target_dec[i] = target_reg[i][VEL_WIDTH-1]
                    ? -$signed(dec_prod[i][VEL_WIDTH+15:16])
                    : $signed(dec_prod[i][VEL_WIDTH+15:16]);
            end
            else
            begin
                target_dec[i] = target_reg[i];
            end
        end
        fsq = 48'(force_x * force_x) + 48'(force_y * force_y) + 48'(force_z * force_z);
        fsq16 = {fsq, 4'b0};
        thr = 52'(9 * 52'(force_lim_reg) * 52'(force_lim_reg));
        clamp_new = fsq16 > thr;
    end

    // difference for the current group
    logic signed [DIFF_W-1:0] diff_new [3];
    logic [SQ_W-1:0] sumsq;
    logic [DIFF_W-1:0] dmag [3];

    always_comb
    begin
        sumsq = '0;
        for (int i = 0; i < 3; i++)
        begin
            logic signed [VEL_WIDTH-1:0] aim;
            logic [2:0] idx;
            idx = cmd.group ? 3'(i + 3) : 3'(i);
            aim = target_reg[idx];
            if (clamp_reg && (cmd.group || (fsign_reg[i] != target_reg[idx][VEL_WIDTH-1])))
            begin
                aim = '0;
            end
            diff_new[i] = DIFF_W'(aim) - DIFF_W'(shaped_reg[idx]);
            dmag[i] = diff_reg[i][DIFF_W-1] ? (~diff_reg[i] + 1'b1) : diff_reg[i];
        end
    end

    // square root: restoring, one bit a cycle
    logic [SQ_W-1:0] rad_reg;
    logic [ROOT_W+1:0] rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [ROOT_CNT_W-1:0] rcnt_reg;
    logic sq_busy_reg;
    logic [1:0] sq_acc_reg;
    logic [ROOT_W+1:0] trial;
    logic [ROOT_W-1:0] root_nxt;

    assign trial = {rem_reg[ROOT_W-1:0], rad_reg[SQ_W-1:SQ_W-2]}
                   - {root_reg, 2'b01};
    assign root_nxt = trial[ROOT_W+1] ? {root_reg[ROOT_W-2:0], 1'b0}
                                      : {root_reg[ROOT_W-2:0], 1'b1};

    // divider: restoring, one bit a cycle
    logic [PROD_W-1:0] dnum_reg;
    logic [ROOT_W:0] drem_reg;
    logic [DIV_CNT_W-1:0] dcnt_reg;
    logic dv_busy_reg;
    logic [ROOT_W:0] dtrial;
    logic [23:0] step_sel;
    assign step_sel = cmd.group ? ang_step_reg : lin_step_reg;
    assign dtrial = {drem_reg[ROOT_W-1:0], dnum_reg[PROD_W-1]} - {1'b0, norm_reg};

    logic sq_finish;
    assign sq_finish = sq_busy_reg && (sq_acc_reg == 2'd3) && (rcnt_reg == '0);
    assign status.sqrt_done = sq_finish;
    assign status.div_done = dv_busy_reg && (dcnt_reg == '0);
    assign status.need_scale = root_nxt > {{(ROOT_W - 24){1'b0}}, step_sel};

    logic [SQ_W-1:0] sq_term;
    logic [1:0] acc_idx;
    assign acc_idx = sq_acc_reg;
    always_comb
    begin
        logic [DIFF_W-1:0] m;
        m = dmag[(acc_idx == 2'd3) ? 2'd0 : acc_idx];
        sq_term = SQ_W'(m * m);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decay_reg <= 16'd65208;
            timeout_reg <= 23'd200000;
            force_lim_reg <= 23'd128000;
            lin_step_reg <= 24'd13422;
            ang_step_reg <= 24'd41943;
            for (int i = 0; i < 6; i++)
            begin
                target_reg[i] <= '0;
                shaped_reg[i] <= '0;
            end
            silence_reg <= '0;
            fresh_reg <= 1'b0;
            clamp_reg <= 1'b0;
            sq_busy_reg <= 1'b0;
            dv_busy_reg <= 1'b0;
            sq_acc_reg <= '0;
            rcnt_reg <= '0;
            dcnt_reg <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_DECAY: decay_reg <= cfg_data[15:0];
                    REG_TIMEOUT: timeout_reg <= cfg_data[22:0];
                    REG_FORCE: force_lim_reg <= cfg_data[22:0];
                    REG_LIN_STEP: lin_step_reg <= cfg_data;
                    REG_ANG_STEP: ang_step_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.load_cmd)
            begin
                for (int i = 0; i < 6; i++)
                begin
                    target_reg[i] <= VEL_WIDTH'(cmd_in[i]);
                    if (!command_ok)
                    begin
                        shaped_reg[i] <= '0;
                    end
                end
                fresh_reg <= 1'b1;
            end
            if (cmd.clear_target)
            begin
                for (int i = 0; i < 6; i++)
                begin
                    target_reg[i] <= '0;
                end
            end
            if (cmd.tick_front)
            begin
                silence_reg <= sil_new;
                fresh_reg <= 1'b0;
                for (int i = 0; i < 6; i++)
                begin
                    target_reg[i] <= target_dec[i];
                end
                clamp_reg <= clamp_new;
                fsign_reg <= {force_z[23], force_y[23], force_x[23]};
            end
            if (cmd.diff_load)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    diff_reg[i] <= diff_new[i];
                end
            end
            // sqrt: accumulate the three squares, then one bit a cycle
            if (cmd.sqrt_start)
            begin
                sq_busy_reg <= 1'b1;
                sq_acc_reg <= 2'd0;
                rad_reg <= '0;
            end
            else if (sq_busy_reg)
            begin
                if (sq_acc_reg != 2'd3)
                begin
                    rad_reg <= rad_reg + sq_term;
                    sq_acc_reg <= sq_acc_reg + 2'd1;
                    rem_reg <= '0;
                    root_reg <= '0;
                    rcnt_reg <= ROOT_CNT_W'(ROOT_W - 1);
                    for (int i = 0; i < 3; i++)
                    begin
                        delta_reg[i] <= diff_reg[i];
                    end
                end
                else
                begin
                    rad_reg <= {rad_reg[SQ_W-3:0], 2'b00};
                    root_reg <= root_nxt;
                    if (trial[ROOT_W+1])
                    begin
                        rem_reg <= {rem_reg[ROOT_W-1:0], rad_reg[SQ_W-1:SQ_W-2]};
                    end
                    else
                    begin
                        rem_reg <= trial;
                    end
                    if (rcnt_reg == '0)
                    begin
                        sq_busy_reg <= 1'b0;
                        norm_reg <= root_nxt;
                    end
                    else
                    begin
                        rcnt_reg <= rcnt_reg - 1'b1;
                    end
                end
            end
            if (cmd.div_start)
            begin
                dv_busy_reg <= 1'b1;
                dnum_reg <= PROD_W'(dmag[cmd.axis] * step_sel);
                drem_reg <= '0;
                dcnt_reg <= DIV_CNT_W'(PROD_W - 1);
            end
            else if (dv_busy_reg)
            begin
                if (dtrial[ROOT_W])
                begin
                    drem_reg <= {drem_reg[ROOT_W-1:0], dnum_reg[PROD_W-1]};
                    dnum_reg <= {dnum_reg[PROD_W-2:0], 1'b0};
                end
                else
                begin
                    drem_reg <= dtrial;
                    dnum_reg <= {dnum_reg[PROD_W-2:0], 1'b1};
                end
                if (dcnt_reg == '0)
                begin
                    dv_busy_reg <= 1'b0;
                    delta_reg[cmd.axis] <= diff_reg[cmd.axis][DIFF_W-1]
                        ? -$signed(DIFF_W'({dnum_reg[PROD_W-2:0], ~dtrial[ROOT_W]}))
                        : $signed(DIFF_W'({dnum_reg[PROD_W-2:0], ~dtrial[ROOT_W]}));
                end
                else
                begin
                    dcnt_reg <= dcnt_reg - 1'b1;
                end
            end
            if (cmd.commit)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    logic signed [DIFF_W:0] s;
                    logic [2:0] idx;
                    idx = cmd.group ? 3'(i + 3) : 3'(i);
                    s = (DIFF_W + 1)'(shaped_reg[idx]) + (DIFF_W + 1)'(delta_reg[i]);
                    if (s > $signed({3'b000, {(VEL_WIDTH - 1){1'b1}}}))
                    begin
                        shaped_reg[idx] <= {1'b0, {(VEL_WIDTH - 1){1'b1}}};
                    end
                    else if (s < $signed({3'b111, {(VEL_WIDTH - 1){1'b0}}}))
                    begin
                        shaped_reg[idx] <= {1'b1, {(VEL_WIDTH - 1){1'b0}}};
                    end
                    else
                    begin
                        shaped_reg[idx] <= VEL_WIDTH'(s);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            for (int i = 0; i < 6; i++)
            begin
                out_reg[i] <= 32'(shaped_reg[i]);
            end
            out_clamp_reg <= clamp_reg;
        end
    end

    assign out_lin_x = out_reg[0];
    assign out_lin_y = out_reg[1];
    assign out_lin_z = out_reg[2];
    assign out_ang_x = out_reg[3];
    assign out_ang_y = out_reg[4];
    assign out_ang_z = out_reg[5];
    assign force_clamped = out_clamp_reg;

endmodule

// ===== rtl/velocity_command_slew_limiter.sv =====
// A mode 0 tick gives a result; the divider also runs for each axis of a group
//   whose step norm must be scaled. Modes 1 and 2 give no result.
// One item at a time: no new item is taken while a tick or its result is pending.
// The bit-serial square root and divider set the tick length.
// Reset (rst_n, asynchronous, active low) zeroes velocities, timer and fresh flag
//   and loads the register defaults.
module velocity_command_slew_limiter
    import vcsl_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          mode,
    input  logic signed [31:0]  lin_x,
    input  logic signed [31:0]  lin_y,
    input  logic signed [31:0]  lin_z,
    input  logic signed [31:0]  ang_x,
    input  logic signed [31:0]  ang_y,
    input  logic signed [31:0]  ang_z,
    input  logic signed [23:0]  force_x,
    input  logic signed [23:0]  force_y,
    input  logic signed [23:0]  force_z,
    input  logic [19:0]         period_us,
    input  logic                command_ok,
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [31:0]  out_lin_x,
    output logic signed [31:0]  out_lin_y,
    output logic signed [31:0]  out_lin_z,
    output logic signed [31:0]  out_ang_x,
    output logic signed [31:0]  out_ang_y,
    output logic signed [31:0]  out_ang_z,
    output logic                force_clamped,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [23:0]         cfg_data
);

    vcsl_cmd_t cmd;
    vcsl_status_t status;

    // config is always taken; the host must write only while no item is in flight (not enforced here)
    assign cfg_ready = 1'b1;

    vcsl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .mode      (mode),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .status    (status)
    );

    vcsl_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .lin_x         (lin_x),
        .lin_y         (lin_y),
        .lin_z         (lin_z),
        .ang_x         (ang_x),
        .ang_y         (ang_y),
        .ang_z         (ang_z),
        .force_x       (force_x),
        .force_y       (force_y),
        .force_z       (force_z),
        .period_us     (period_us),
        .command_ok    (command_ok),
        .cmd           (cmd),
        .status        (status),
        .out_lin_x     (out_lin_x),
        .out_lin_y     (out_lin_y),
        .out_lin_z     (out_lin_z),
        .out_ang_x     (out_ang_x),
        .out_ang_y     (out_ang_y),
        .out_ang_z     (out_ang_z),
        .force_clamped (force_clamped)
    );

endmodule

// ===== rtl/vcsl_checker.sv =====
module vcsl_checker
(
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic force_clamped
);

    a_no_accept_while_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready) else $error("input taken while result pending");

    a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(force_clamped))
        else $error("result dropped");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !out_valid) else $error("result too early");

endmodule

bind velocity_command_slew_limiter vcsl_checker u_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .force_clamped (force_clamped)
);

// ===== verif/velocity_command_slew_limiter_test.sv =====
`timescale 1ns / 1ps

module velocity_command_slew_limiter_test;
    import vcsl_pkg::*;

    // one command/tick item as the driver presents it
    typedef struct {
        logic [1:0]         mode;
        logic signed [31:0] vel [6];
        logic signed [23:0] frc [3];
        logic [19:0]        period;
        logic               ok;
    } cmd_item_t;

    // one shaped velocity result
    typedef struct {
        logic signed [31:0] vel [6];
        logic               clamped;
    } shaped_out_t;

    localparam int STALL_LIMIT = 20000;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic [1:0] mode;
    logic signed [31:0] lin_x, lin_y, lin_z, ang_x, ang_y, ang_z;
    logic signed [23:0] force_x, force_y, force_z;
    logic [19:0] period_us;
    logic command_ok;
    logic out_valid;
    logic out_ready;
    logic signed [31:0] out_lin_x, out_lin_y, out_lin_z, out_ang_x, out_ang_y, out_ang_z;
    logic force_clamped;
    logic cfg_valid;
    logic cfg_ready;
    logic [2:0] cfg_index;
    logic [23:0] cfg_data;

    velocity_command_slew_limiter uut (.*);

    // predictor state: registers and block state mirror
    longint unsigned gain_q16, timeout_cfg, flimit_cfg, lin_step_cfg, ang_step_cfg;
    longint target_vel [6];
    longint shaped_vel [6];
    longint unsigned silence_us;
    bit cmd_fresh;

    cmd_item_t   pending_items [$];
    shaped_out_t shaped_expected [$];

    int errors = 0;
    int ticks_checked = 0;
    int clamps_seen = 0;
    int items_sent = 0;
    int watchdog = 0;
    bit idle_enable = 1;
    bit stim_done = 0;
    bit in_accepted = 0;

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // 128-bit helpers: squared norms of 33-bit differences need > 64 bits
    function automatic longint unsigned isqrt128(logic [127:0] n);
        logic [127:0] r;
        logic [127:0] c;
        r = 0;
        for (int b = 63; b >= 0; b--)
        begin
            c = r | (128'd1 << b);
            if (c * c <= n)
                r = c;
        end
        return r[63:0];
    endfunction

    function automatic longint sat_w(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint unsigned mag64(longint v);
        return v < 0 ? longint'(-v) : longint'(v);
    endfunction

    // move one axis group of the shaped velocity toward its aim, norm-limited
    task automatic slew_axes(int base, longint dlt [6], longint unsigned lim);
        logic [127:0] sumsq;
        logic [127:0] prod;
        longint unsigned nrm;
        longint c;
        sumsq = 0;
        for (int i = 0; i < 3; i++)
            sumsq += 128'(mag64(dlt[base + i])) * 128'(mag64(dlt[base + i]));
        nrm = isqrt128(sumsq);
        for (int i = 0; i < 3; i++)
        begin
            c = dlt[base + i];
            if (nrm > lim)
            begin
                prod = 128'(mag64(c)) * 128'(lim) / 128'(nrm);
                c = c < 0 ? -longint'(prod[63:0]) : longint'(prod[63:0]);
            end
            shaped_vel[base + i] = sat_w(shaped_vel[base + i] + c);
        end
    endtask

    // apply one accepted item; ticks push the expected shaped output
    task automatic predict_shaping(cmd_item_t it);
        longint dlt [6];
        longint aim;
        longint unsigned fsq;
        longint unsigned p;
        bit clamp;
        shaped_out_t r;
        if (it.mode == MODE_CMD)
        begin
            for (int i = 0; i < 6; i++)
                target_vel[i] = it.vel[i];
            cmd_fresh = 1;
            if (!it.ok)
                for (int i = 0; i < 6; i++)
                    shaped_vel[i] = 0;
            return;
        end
        if (it.mode == MODE_CLEAR)
        begin
            for (int i = 0; i < 6; i++)
                target_vel[i] = 0;
            return;
        end
        if (it.mode != MODE_TICK)
            return;
        if (cmd_fresh)
        begin
            silence_us = 0;
            cmd_fresh = 0;
        end
        else
        begin
            silence_us += it.period;
            if (silence_us > 64'hFFFFFF)
                silence_us = 64'hFFFFFF;
        end
        if (silence_us > 2 * timeout_cfg)
            for (int i = 0; i < 6; i++)
            begin
                p = (mag64(target_vel[i]) * gain_q16) >> 16;
                target_vel[i] = target_vel[i] < 0 ? -longint'(p) : longint'(p);
            end
        fsq = 0;
        for (int i = 0; i < 3; i++)
            fsq += mag64(it.frc[i]) * mag64(it.frc[i]);
        clamp = 16 * fsq > 9 * flimit_cfg * flimit_cfg;
        for (int i = 0; i < 6; i++)
        begin
            aim = target_vel[i];
            if (clamp)
            begin
                if (i >= 3)
                    aim = 0;
                else if ((it.frc[i] < 0) != (target_vel[i] < 0))
                    aim = 0;
            end
            dlt[i] = aim - shaped_vel[i];
        end
        slew_axes(0, dlt, lin_step_cfg);
        slew_axes(3, dlt, ang_step_cfg);
        for (int i = 0; i < 6; i++)
            r.vel[i] = shaped_vel[i][31:0];
        r.clamped = clamp;
        shaped_expected.push_back(r);
    endtask

    // driver: present queued items, random idle bursts between them
    int in_gap = 0;
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || in_accepted)
            begin
                if (in_gap > 0)
                begin
                    in_gap <= in_gap - 1;
                    in_valid <= 0;
                end
                else if (pending_items.size() > 0)
                begin
                    cmd_item_t it;
                    it = pending_items.pop_front();
                    mode <= it.mode;
                    lin_x <= it.vel[0];
                    lin_y <= it.vel[1];
                    lin_z <= it.vel[2];
                    ang_x <= it.vel[3];
                    ang_y <= it.vel[4];
                    ang_z <= it.vel[5];
                    force_x <= it.frc[0];
                    force_y <= it.frc[1];
                    force_z <= it.frc[2];
                    period_us <= it.period;
                    command_ok <= it.ok;
                    in_valid <= 1;
                    if (idle_enable && $urandom_range(0, 5) == 0)
                        in_gap <= $urandom_range(1, 11);
                end
                else
                    in_valid <= 0;
            end
        end
    end

    // receiver backpressure in bursts
    int out_stall = 0;
    always @(negedge clk)
    begin
        if (out_stall > 0)
        begin
            out_stall <= out_stall - 1;
            out_ready <= 0;
        end
        else if (idle_enable && $urandom_range(0, 7) == 0)
        begin
            out_stall <= $urandom_range(1, 11);
            out_ready <= 0;
        end
        else
            out_ready <= 1;
    end

    // monitor: predict on accepted inputs, compare accepted results
    always @(posedge clk)
    begin
        in_accepted <= in_valid && in_ready;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                cmd_item_t it;
                it.mode = mode;
                it.vel[0] = lin_x; it.vel[1] = lin_y; it.vel[2] = lin_z;
                it.vel[3] = ang_x; it.vel[4] = ang_y; it.vel[5] = ang_z;
                it.frc[0] = force_x; it.frc[1] = force_y; it.frc[2] = force_z;
                it.period = period_us;
                it.ok = command_ok;
                predict_shaping(it);
                items_sent++;
            end
            if (out_valid && out_ready)
            begin
                shaped_out_t exp_r;
                logic signed [31:0] got [6];
                got[0] = out_lin_x; got[1] = out_lin_y; got[2] = out_lin_z;
                got[3] = out_ang_x; got[4] = out_ang_y; got[5] = out_ang_z;
                if (shaped_expected.size() == 0)
                begin
                    $display("%0t: unexpected result, lin_x %0d", $time, out_lin_x);
                    errors++;
                end
                else
                begin
                    exp_r = shaped_expected.pop_front();
                    ticks_checked++;
                    if (force_clamped)
                        clamps_seen++;
                    for (int i = 0; i < 6; i++)
                        if (got[i] !== exp_r.vel[i])
                        begin
                            $display("%0t: axis %0d expected %0d actual %0d",
                                     $time, i, exp_r.vel[i], got[i]);
                            errors++;
                        end
                    if (force_clamped !== exp_r.clamped)
                    begin
                        $display("%0t: force_clamped expected %0b actual %0b",
                                 $time, exp_r.clamped, force_clamped);
                        errors++;
                    end
                end
            end
            // watchdog on cycles without any accepted item
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                watchdog <= 0;
            else if (!stim_done)
                watchdog <= watchdog + 1;
            if (watchdog >= STALL_LIMIT)
            begin
                $display("timeout, %0d results outstanding", shaped_expected.size());
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // register write: idle block only, mirrors into predictor on acceptance
    task automatic write_reg(logic [2:0] idx, logic [23:0] val);
        @(negedge clk);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_DECAY:    gain_q16 = val[15:0];
            REG_TIMEOUT:  timeout_cfg = val[22:0];
            REG_FORCE:    flimit_cfg = val[22:0];
            REG_LIN_STEP: lin_step_cfg = val;
            REG_ANG_STEP: ang_step_cfg = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 0;
    endtask

    // wait for the driver queue and expectations to drain, then tick latency margin
    task automatic drain();
        while (pending_items.size() > 0 || in_valid || shaped_expected.size() > 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
    endtask

    function automatic cmd_item_t mk_item(logic [1:0] m);
        cmd_item_t it;
        it.mode = m;
        for (int i = 0; i < 6; i++)
            it.vel[i] = $urandom;
        for (int i = 0; i < 3; i++)
            it.frc[i] = 24'($urandom);
        it.period = 20'($urandom);
        it.ok = 1'($urandom_range(0, 1));
        return it;
    endfunction

    // command: half small velocities so slews land on target, half full-range
    function automatic cmd_item_t rand_cmd();
        cmd_item_t it;
        it = mk_item(MODE_CMD);
        for (int i = 0; i < 6; i++)
            case ($urandom_range(0, 3))
                0: it.vel[i] = $signed($urandom_range(0, 200000)) - 100000;
                1: it.vel[i] = $signed($urandom_range(0, 40000000)) - 20000000;
                default: it.vel[i] = $urandom;
            endcase
        it.ok = $urandom_range(0, 4) != 0;
        return it;
    endfunction

    function automatic cmd_item_t rand_tick();
        cmd_item_t it;
        it = mk_item(MODE_TICK);
        // forces mostly near the clamp threshold of the current limit
        for (int i = 0; i < 3; i++)
            if ($urandom_range(0, 2) != 0)
                it.frc[i] = 24'($signed($urandom_range(0, 2 * flimit_cfg))
                                - longint'(flimit_cfg));
        if ($urandom_range(0, 2) != 0)
            it.period = 20'($urandom_range(0, 3000));
        return it;
    endfunction

    task automatic random_phase(int n);
        int r;
        for (int k = 0; k < n; k++)
        begin
            r = $urandom_range(0, 99);
            if (r < 12)
                pending_items.push_back(rand_cmd());
            else if (r < 15)
                pending_items.push_back(mk_item(MODE_CLEAR));
            else if (r < 17)
                pending_items.push_back(mk_item(MODE_UNUSED));
            else
                pending_items.push_back(rand_tick());
        end
    endtask

    initial
    begin
        cmd_item_t it;
        rst_n = 0;
        in_valid = 0;
        out_ready = 0;
        cfg_valid = 0;
        cfg_index = REG_DECAY;
        cfg_data = 0;
        mode = MODE_TICK;
        {lin_x, lin_y, lin_z, ang_x, ang_y, ang_z} = '0;
        {force_x, force_y, force_z} = '0;
        period_us = 0;
        command_ok = 0;
        gain_q16 = 65208; timeout_cfg = 200000; flimit_cfg = 128000;
        lin_step_cfg = 13422; ang_step_cfg = 41943;
        for (int i = 0; i < 6; i++)
        begin
            target_vel[i] = 0;
            shaped_vel[i] = 0;
        end
        silence_us = 0;
        cmd_fresh = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // directed: field extremes, all modes, unused mode, ok low, saturation
        it = mk_item(MODE_CMD);
        for (int i = 0; i < 6; i++)
            it.vel[i] = (i % 2) ? 32'sh7FFFFFFF : 32'sh80000000;
        it.ok = 1;
        pending_items.push_back(it);
        for (int k = 0; k < 3; k++)
        begin
            it = mk_item(MODE_TICK);
            it.frc[0] = 24'sh7FFFFF; it.frc[1] = 24'sh800000; it.frc[2] = 0;
            it.period = 20'hFFFFF;
            pending_items.push_back(it);
        end
        it = mk_item(MODE_TICK);
        it.frc[0] = 0; it.frc[1] = 0; it.frc[2] = 0; it.period = 0;
        pending_items.push_back(it);
        pending_items.push_back(mk_item(MODE_UNUSED));
        it = mk_item(MODE_CMD);
        it.ok = 0;
        pending_items.push_back(it);
        pending_items.push_back(mk_item(MODE_TICK));
        pending_items.push_back(mk_item(MODE_CLEAR));
        for (int k = 0; k < 20; k++)
        begin
            // long silence saturates the timer and triggers decay
            it = mk_item(MODE_TICK);
            it.period = 20'hFFFFF;
            it.frc[0] = 0; it.frc[1] = 0; it.frc[2] = 0;
            pending_items.push_back(it);
            if (k == 2)
                pending_items.push_back(rand_cmd());
        end
        drain();

        // random phases under several register settings, extremes included
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: begin
                    write_reg(REG_DECAY, 0); write_reg(REG_TIMEOUT, 0);
                    write_reg(REG_FORCE, 0); write_reg(REG_LIN_STEP, 0);
                    write_reg(REG_ANG_STEP, 0);
                end
                1: begin
                    write_reg(REG_DECAY, 24'hFFFF); write_reg(REG_TIMEOUT, 24'h7FFFFF);
                    write_reg(REG_FORCE, 24'h7FFFFF); write_reg(REG_LIN_STEP, 24'hFFFFFF);
                    write_reg(REG_ANG_STEP, 24'hFFFFFF);
                end
                2: begin
                    write_reg(REG_DECAY, 65208); write_reg(REG_TIMEOUT, 2000);
                    write_reg(REG_FORCE, 128000); write_reg(REG_LIN_STEP, 13422);
                    write_reg(REG_ANG_STEP, 41943);
                end
                default: begin
                    write_reg(REG_DECAY, 24'($urandom_range(0, 65535)));
                    write_reg(REG_TIMEOUT, 24'($urandom_range(0, 20000)));
                    write_reg(REG_FORCE, 24'($urandom_range(0, 8388607)));
                    write_reg(REG_LIN_STEP, 24'($urandom_range(0, 16777215)));
                    write_reg(REG_ANG_STEP, 24'($urandom_range(0, 1000000)));
                end
            endcase
            if (ph == 5)
                idle_enable = 0;
            random_phase(210);
            drain();
        end

        stim_done = 1;
        $display("covered %0d items, %0d ticks checked, %0d with force clamp",
                 items_sent, ticks_checked, clamps_seen);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
